>>> hw/rtl/mmhq_pkg.sv
// ----------------------------------------------------------------------------
// mmhq_pkg
// Shared types and constants of the min-max heap queue: operation and status
// codes, the datapath command set and the datapath status group.
// ----------------------------------------------------------------------------
package mmhq_pkg;

  localparam int DEF_CAPACITY = 1024;
  localparam int KEY_W        = 32;
  localparam int SUM_W        = 64;
  localparam int OP_W         = 2;
  localparam int STAT_W       = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT  = 2'd0,
    OP_POP_MIN = 2'd1,
    OP_POP_MAX = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_RSVD  = 2'd3
  } stat_code_t;

  // One command per cycle from the controller to the datapath
  typedef enum logic [4:0] {
    CMD_IDLE,
    CMD_DISPATCH,
    CMD_I_PAR_RD,
    CMD_I_PAR_CMP,
    CMD_I_GP_RD,
    CMD_I_GP_CMP,
    CMD_M2_RD,
    CMD_M3_RD,
    CMD_M_SEL,
    CMD_R_TOP_RD,
    CMD_R_LAST_RD,
    CMD_R_LAST_CAP,
    CMD_SCAN_START,
    CMD_SCAN,
    CMD_DECIDE,
    CMD_G_PAR,
    CMD_WR_HOLE,
    CMD_DONE
  } cmd_t;

  // Datapath status seen by the controller
  typedef struct packed {
    op_t  op;
    logic in_req;
    logic full;
    logic empty;
    logic first_ins;
    logic max_small;
    logic i_gt3;
    logic gp_stop;
    logic c_ok;
    logic scan_more;
    logic keep;
    logic is_child;
    logic out_free;
  } dp_stat_t;

endpackage

>>> hw/rtl/mmhq_ram.sv
// ----------------------------------------------------------------------------
// mmhq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mmhq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

>>> hw/rtl/mmhq_ctrl.sv
// ----------------------------------------------------------------------------
// mmhq_ctrl
// Sequencer of the min-max heap queue. Walks insert sift-up and removal
// trickle-down one memory access per cycle and issues datapath commands.
// ----------------------------------------------------------------------------
module mmhq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  mmhq_pkg::dp_stat_t stat,
  output logic               in_stall,
  output mmhq_pkg::cmd_t     cmd
);
  import mmhq_pkg::*;

  typedef enum logic [17:0] {
    S_IDLE       = 18'b000000000000000001,
    S_DISPATCH   = 18'b000000000000000010,
    S_I_PAR_RD   = 18'b000000000000000100,
    S_I_PAR_CMP  = 18'b000000000000001000,
    S_I_GP_RD    = 18'b000000000000010000,
    S_I_GP_CMP   = 18'b000000000000100000,
    S_M2_RD      = 18'b000000000001000000,
    S_M3_RD      = 18'b000000000010000000,
    S_M_SEL      = 18'b000000000100000000,
    S_R_TOP_RD   = 18'b000000001000000000,
    S_R_LAST_RD  = 18'b000000010000000000,
    S_R_LAST_CAP = 18'b000000100000000000,
    S_SCAN_START = 18'b000001000000000000,
    S_SCAN       = 18'b000010000000000000,
    S_DECIDE     = 18'b000100000000000000,
    S_G_PAR      = 18'b001000000000000000,
    S_WR_HOLE    = 18'b010000000000000000,
    S_DONE       = 18'b100000000000000000
  } state_t;

  state_t state_r, state_nxt;

  // Hold the state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  // Pick the next step from datapath status
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        // Stay idle until a request arrives
        state_nxt = stat.in_req ? S_DISPATCH : S_IDLE;
      end
      S_DISPATCH: begin
        case (stat.op)
          OP_INSERT: begin
            if (stat.full) state_nxt = S_DONE;
            else if (stat.first_ins) state_nxt = S_WR_HOLE;
            else state_nxt = S_I_PAR_RD;
          end
          OP_POP_MIN: begin
            state_nxt = stat.empty ? S_DONE : S_R_TOP_RD;
          end
          OP_POP_MAX: begin
            if (stat.empty) state_nxt = S_DONE;
            else if (stat.max_small) state_nxt = S_R_TOP_RD;
            else state_nxt = S_M2_RD;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_I_PAR_RD:   state_nxt = S_I_PAR_CMP;
      S_I_PAR_CMP:  state_nxt = S_I_GP_RD;
      S_I_GP_RD:    state_nxt = stat.i_gt3 ? S_I_GP_CMP : S_WR_HOLE;
      S_I_GP_CMP:   state_nxt = stat.gp_stop ? S_WR_HOLE : S_I_GP_RD;
      S_M2_RD:      state_nxt = S_M3_RD;
      S_M3_RD:      state_nxt = S_M_SEL;
      S_M_SEL:      state_nxt = S_R_TOP_RD;
      S_R_TOP_RD:   state_nxt = S_R_LAST_RD;
      S_R_LAST_RD:  state_nxt = S_R_LAST_CAP;
      S_R_LAST_CAP: state_nxt = S_SCAN_START;
      S_SCAN_START: state_nxt = stat.c_ok ? S_SCAN : S_WR_HOLE;
      S_SCAN:       state_nxt = stat.scan_more ? S_SCAN : S_DECIDE;
      S_DECIDE: begin
        if (stat.keep || stat.is_child) state_nxt = S_WR_HOLE;
        else state_nxt = S_G_PAR;
      end
      S_G_PAR:      state_nxt = S_SCAN_START;
      S_WR_HOLE:    state_nxt = S_DONE;
      S_DONE:       state_nxt = stat.out_free ? S_IDLE : S_DONE;
      default:      state_nxt = S_IDLE;
    endcase
  end

  // Map state to datapath command
  always_comb begin
    case (state_r)
      S_IDLE:       cmd = CMD_IDLE;
      S_DISPATCH:   cmd = CMD_DISPATCH;
      S_I_PAR_RD:   cmd = CMD_I_PAR_RD;
      S_I_PAR_CMP:  cmd = CMD_I_PAR_CMP;
      S_I_GP_RD:    cmd = CMD_I_GP_RD;
      S_I_GP_CMP:   cmd = CMD_I_GP_CMP;
      S_M2_RD:      cmd = CMD_M2_RD;
      S_M3_RD:      cmd = CMD_M3_RD;
      S_M_SEL:      cmd = CMD_M_SEL;
      S_R_TOP_RD:   cmd = CMD_R_TOP_RD;
      S_R_LAST_RD:  cmd = CMD_R_LAST_RD;
      S_R_LAST_CAP: cmd = CMD_R_LAST_CAP;
      S_SCAN_START: cmd = CMD_SCAN_START;
      S_SCAN:       cmd = CMD_SCAN;
      S_DECIDE:     cmd = CMD_DECIDE;
      S_G_PAR:      cmd = CMD_G_PAR;
      S_WR_HOLE:    cmd = CMD_WR_HOLE;
      S_DONE:       cmd = CMD_DONE;
      default:      cmd = CMD_IDLE;
    endcase
  end

endmodule

>>> hw/rtl/mmhq_dp.sv
// ----------------------------------------------------------------------------
// mmhq_dp
// Datapath of the min-max heap queue: key memory, walk position, moving key,
// candidate scan, count and sum registers, and the result register.
// ----------------------------------------------------------------------------
module mmhq_dp #(
  parameter int CAPACITY = mmhq_pkg::DEF_CAPACITY,
  localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mmhq_pkg::cmd_t                cmd,
  output mmhq_pkg::dp_stat_t            stat,
  input  logic                          in_valid,
  input  logic [mmhq_pkg::OP_W-1:0]     in_operation,
  input  logic signed [mmhq_pkg::KEY_W-1:0] in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [mmhq_pkg::KEY_W-1:0] out_removed_value,
  output logic [CNT_W-1:0]              out_entry_count,
  output logic signed [mmhq_pkg::SUM_W-1:0] out_running_total,
  output logic [mmhq_pkg::STAT_W-1:0]   out_status
);
  import mmhq_pkg::*;

  localparam int AW       = $clog2(CAPACITY);
  localparam int POS_W    = CNT_W + 2;
  localparam int NUM_CAND = 6;
  localparam int J_W      = 3;

  // Request and walk registers
  op_t                     op_r;
  logic signed [KEY_W-1:0] v_r;
  logic signed [KEY_W-1:0] km_r;
  logic signed [KEY_W-1:0] ret_r;
  logic [POS_W-1:0]        i_r;
  logic [POS_W-1:0]        m_r;
  logic [POS_W-1:0]        pend_r;
  logic [J_W-1:0]          j_r;
  logic                    mn_r;
  stat_code_t              st_r;
  logic [CNT_W-1:0]        cnt_r;
  logic signed [SUM_W-1:0] sum_r;
  logic                    out_valid_r;

  logic signed [KEY_W-1:0] rd;
  logic [KEY_W-1:0]        ram_rdata;
  logic [POS_W-1:0]        rpos, wpos, cnt_pos, c_pos, g_base, cand_pos, ins_pos;
  logic                    we;
  logic signed [KEY_W-1:0] wdata;
  logic                    rd_lt_v, take, out_free;

  // Level parity: a position on an even level is a min level
  function automatic logic is_min_level(input logic [POS_W-1:0] p);
    logic odd;
    odd = 1'b0;
    for (int b = 0; b < POS_W; b++) begin
      if (p[b]) odd = 1'(b % 2);
    end
    return !odd;
  endfunction

  mmhq_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_ram (
    .clk    (clk),
    .we     (we),
    .waddr  (AW'(wpos - POS_W'(1))),
    .wdata  (wdata),
    .raddr  (AW'(rpos - POS_W'(1))),
    .rdata_r(ram_rdata)
  );

  assign rd      = $signed(ram_rdata);
  assign cnt_pos = POS_W'(cnt_r);
  assign ins_pos = cnt_pos + POS_W'(1);
  assign c_pos   = i_r << 1;
  assign g_base  = i_r << 2;
  assign rd_lt_v = (rd < v_r);

  // Candidate positions: two children, then four grandchildren
  always_comb begin
    case (j_r)
      3'd0:    cand_pos = c_pos;
      3'd1:    cand_pos = c_pos + POS_W'(1);
      default: cand_pos = g_base + POS_W'(j_r - J_W'(2));
    endcase
  end

  // Keep the better candidate: grandchildren win ties
  always_comb begin
    if (pend_r == c_pos) take = 1'b1;
    else if (pend_r == c_pos + POS_W'(1)) take = (mn_r == (rd < km_r));
    else take = mn_r ? (rd <= km_r) : (rd >= km_r);
  end

  // Read address per step
  always_comb begin
    case (cmd)
      CMD_I_PAR_RD:   rpos = i_r >> 1;
      CMD_I_GP_RD:    rpos = i_r >> 2;
      CMD_M2_RD:      rpos = POS_W'(2);
      CMD_M3_RD:      rpos = POS_W'(3);
      CMD_R_TOP_RD:   rpos = i_r;
      CMD_R_LAST_RD:  rpos = cnt_pos;
      CMD_SCAN_START: rpos = c_pos;
      CMD_SCAN:       rpos = cand_pos;
      CMD_DECIDE:     rpos = m_r >> 1;
      default:        rpos = POS_W'(1);
    endcase
  end

  // Write port per step
  always_comb begin
    we    = 1'b0;
    wpos  = i_r;
    wdata = v_r;
    case (cmd)
      CMD_I_PAR_CMP: begin
        we    = (mn_r == rd_lt_v);
        wdata = rd;
      end
      CMD_I_GP_CMP: begin
        we    = (mn_r != rd_lt_v);
        wdata = rd;
      end
      CMD_DECIDE: begin
        we    = !stat.keep;
        wdata = km_r;
      end
      CMD_G_PAR: begin
        we    = (mn_r == (v_r > rd));
        wpos  = i_r >> 1;
      end
      CMD_WR_HOLE: begin
        we    = 1'b1;
      end
      default: begin
        we    = 1'b0;
      end
    endcase
  end

  assign out_free = !out_valid_r || !out_stall;

  // Status for the controller
  always_comb begin
    stat.op        = op_r;
    stat.in_req    = in_valid;
    stat.full      = (cnt_r >= CNT_W'(CAPACITY));
    stat.empty     = (cnt_r == '0);
    stat.first_ins = (cnt_r == '0);
    stat.max_small = (cnt_r <= CNT_W'(2));
    stat.i_gt3     = (i_r > POS_W'(3));
    stat.gp_stop   = (mn_r == rd_lt_v);
    stat.c_ok      = (c_pos <= cnt_pos);
    stat.scan_more = (j_r < J_W'(NUM_CAND)) && (cand_pos <= cnt_pos);
    stat.keep      = (mn_r == (v_r < km_r));
    stat.is_child  = (m_r < g_base);
    stat.out_free  = out_free;
  end

  // Control registers: count and sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      sum_r <= '0;
    end else begin
      case (cmd)
        CMD_DISPATCH: begin
          if (op_r == OP_INSERT && !stat.full) begin
            cnt_r <= cnt_r + CNT_W'(1);
            sum_r <= sum_r + {{(SUM_W-KEY_W){v_r[KEY_W-1]}}, v_r};
          end
        end
        CMD_R_LAST_CAP: cnt_r <= cnt_r - CNT_W'(1);
        CMD_WR_HOLE: begin
          if (op_r != OP_INSERT) begin
            sum_r <= sum_r - {{(SUM_W-KEY_W){ret_r[KEY_W-1]}}, ret_r};
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result valid: set on a finished request, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd == CMD_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Walk registers: advance per command
  always_ff @(posedge clk) begin
    case (cmd)
      CMD_IDLE: begin
        if (in_valid) begin
          op_r  <= op_t'(in_operation);
          v_r   <= in_value;
          ret_r <= '0;
          st_r  <= STAT_OK;
        end
      end
      CMD_DISPATCH: begin
        case (op_r)
          OP_INSERT: begin
            if (stat.full) begin
              st_r <= STAT_FULL;
            end else begin
              i_r  <= ins_pos;
              mn_r <= is_min_level(ins_pos);
            end
          end
          OP_POP_MIN: begin
            if (stat.empty) st_r <= STAT_EMPTY;
            i_r  <= POS_W'(1);
            mn_r <= 1'b1;
          end
          OP_POP_MAX: begin
            if (stat.empty) st_r <= STAT_EMPTY;
            i_r  <= (cnt_r == CNT_W'(1)) ? POS_W'(1) : POS_W'(2);
            mn_r <= 1'b0;
          end
          default: begin
          end
        endcase
      end
      CMD_I_PAR_CMP: begin
        if (mn_r == rd_lt_v) begin
          i_r  <= i_r >> 1;
          mn_r <= !mn_r;
        end
      end
      CMD_I_GP_CMP: begin
        if (mn_r != rd_lt_v) i_r <= i_r >> 2;
      end
      CMD_M3_RD:      km_r  <= rd;
      CMD_M_SEL:      i_r   <= (km_r > rd) ? POS_W'(2) : POS_W'(3);
      CMD_R_LAST_RD:  ret_r <= rd;
      CMD_R_LAST_CAP: v_r   <= rd;
      CMD_SCAN_START: begin
        pend_r <= c_pos;
        j_r    <= J_W'(1);
      end
      CMD_SCAN: begin
        if (take) begin
          m_r  <= pend_r;
          km_r <= rd;
        end
        if (stat.scan_more) begin
          pend_r <= cand_pos;
          j_r    <= j_r + J_W'(1);
        end
      end
      CMD_DECIDE: begin
        if (!stat.keep) i_r <= m_r;
      end
      CMD_G_PAR: begin
        if (mn_r == (v_r > rd)) v_r <= rd;
      end
      default: begin
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd == CMD_DONE && out_free) begin
      out_removed_value <= ret_r;
      out_entry_count   <= cnt_r;
      out_running_total <= sum_r;
      out_status        <= st_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> hw/rtl/min_max_heap_queue.sv
// ----------------------------------------------------------------------------
// min_max_heap_queue
// Double-ended priority queue held as a min-max heap with a running key sum.
//
// Input channel (in_valid / in_stall): one request of in_operation and
// in_value; insert, pop-minimum or pop-maximum. Code 3 does nothing.
// Result channel (out_valid / out_stall): one result per request with the
// removed key, the count and sum after the request and an ok/full/empty code.
// The block takes one request at a time and, while it walks the heap, reads one
// key per cycle through the single read port of the key memory. An insert first
// fixes against its parent and then climbs by grandparent swaps. A removal walks
// down grandchild levels, each with up to six candidate reads, a decide and a
// parent fix-up; pop-maximum above two keys first reads both second-level keys.
// The result becomes valid in the same cycle that the next request can be
// taken. When the receiver stalls the result register holds; the next request
// is still taken and walked, and its last step waits until the register frees
// up. Reset empties the heap and clears the sum at once; the key memory needs
// no clearing.
// ----------------------------------------------------------------------------
module min_max_heap_queue #(
  parameter int CAPACITY = mmhq_pkg::DEF_CAPACITY,
  localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [mmhq_pkg::OP_W-1:0]         in_operation,
  input  logic signed [mmhq_pkg::KEY_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [mmhq_pkg::KEY_W-1:0] out_removed_value,
  output logic [CNT_W-1:0]                  out_entry_count,
  output logic signed [mmhq_pkg::SUM_W-1:0] out_running_total,
  output logic [mmhq_pkg::STAT_W-1:0]       out_status
);
  import mmhq_pkg::*;

  cmd_t     cmd;
  dp_stat_t stat;

  mmhq_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .stat    (stat),
    .in_stall(in_stall),
    .cmd     (cmd)
  );

  mmhq_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_valid         (in_valid),
    .in_operation     (in_operation),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_removed_value(out_removed_value),
    .out_entry_count  (out_entry_count),
    .out_running_total(out_running_total),
    .out_status       (out_status)
  );

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the min-max heap queue. A directed table covers
// empty pops, extreme keys, small-heap pop-maximum cases, ties and the unused
// opcode. Random traffic then runs a mixed phase, a fill past capacity and a
// pop-heavy phase. Every result is compared against a typed expectation from the
// table or an in-bench heap model.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mmhq_pkg::*;

  localparam int CAPACITY = DEF_CAPACITY;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef struct {
    int          removed;
    logic [CNT_W-1:0] count;
    longint      total;
    stat_code_t  status;
  } heap_result_t;

  typedef struct {
    op_t         op;
    int          value;
    bit          typed;
    heap_result_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OP_W-1:0] in_operation = OP_NONE;
  logic signed [KEY_W-1:0] in_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [KEY_W-1:0] out_removed_value;
  logic [CNT_W-1:0] out_entry_count;
  logic signed [SUM_W-1:0] out_running_total;
  logic [STAT_W-1:0] out_status;

  // heap model state
  int     heap_keys [1:CAPACITY];
  int     heap_fill = 0;
  longint heap_sum = 0;

  heap_result_t result_q [$];
  int  error_cnt = 0;
  int  result_cnt = 0;
  int  full_cnt = 0;
  int  empty_cnt = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_req = 1'b0;
  bit  hold_seen = 1'b0;
  int  hold_left = 0;

  min_max_heap_queue #(.CAPACITY(CAPACITY)) dut (.*);

  always #2 clk = ~clk;

  function automatic bit on_min_level(int p);
    int lv = 0;
    while (p > 1) begin
      p = p >> 1;
      lv++;
    end
    return (lv % 2) == 0;
  endfunction

  function automatic void heap_swap(int a, int b);
    int t = heap_keys[a];
    heap_keys[a] = heap_keys[b];
    heap_keys[b] = t;
  endfunction

  function automatic void heap_push(int v);
    int i;
    bit mn;
    heap_fill++;
    heap_keys[heap_fill] = v;
    heap_sum += longint'(v);
    if (heap_fill == 1) return;
    i = heap_fill;
    mn = on_min_level(i);
    // fix against parent first, then climb by grandparents
    if (mn == (heap_keys[i>>1] < heap_keys[i])) begin
      heap_swap(i, i >> 1);
      i = i >> 1;
      mn = !mn;
    end
    while (i > 3) begin
      if (mn == (heap_keys[i>>2] < heap_keys[i])) break;
      heap_swap(i, i >> 2);
      i = i >> 2;
    end
  endfunction

  function automatic int heap_take(int i, bit mn);
    int ret = heap_keys[i];
    int c, m, g;
    heap_keys[i] = heap_keys[heap_fill];
    heap_fill--;
    forever begin
      c = i << 1;
      if (c > heap_fill) break;
      m = c;
      if (c + 1 <= heap_fill && mn == (heap_keys[c+1] < heap_keys[c])) m = c + 1;
      // grandchildren win ties against the best child
      for (int j = 0; j < 4; j++) begin
        g = (i << 2) + j;
        if (g <= heap_fill && (mn ? heap_keys[g] <= heap_keys[m]
                                  : heap_keys[g] >= heap_keys[m])) m = g;
      end
      if (mn == (heap_keys[i] < heap_keys[m])) break;
      heap_swap(i, m);
      if (m < (i << 2)) break;
      if (mn == (heap_keys[m] > heap_keys[m>>1])) heap_swap(m, m >> 1);
      i = m;
    end
    heap_sum -= longint'(ret);
    return ret;
  endfunction

  function automatic heap_result_t heap_apply(op_t op, int v);
    heap_result_t r;
    int p;
    r.removed = 0;
    r.status = STAT_OK;
    case (op)
      OP_INSERT: begin
        if (heap_fill >= CAPACITY) r.status = STAT_FULL;
        else heap_push(v);
      end
      OP_POP_MIN: begin
        if (heap_fill == 0) r.status = STAT_EMPTY;
        else r.removed = heap_take(1, 1'b1);
      end
      OP_POP_MAX: begin
        if (heap_fill == 0) r.status = STAT_EMPTY;
        else begin
          if (heap_fill == 1) p = 1;
          else if (heap_fill == 2) p = 2;
          else p = (heap_keys[2] > heap_keys[3]) ? 2 : 3;
          r.removed = heap_take(p, 1'b0);
        end
      end
      default: ;
    endcase
    r.count = heap_fill[CNT_W-1:0];
    r.total = heap_sum;
    return r;
  endfunction

  // Offer one request, idling at random first; record its result on accept
  task automatic send_req(op_t op, int v, bit typed, heap_result_t typed_res);
    heap_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_value <= v;
    do @(posedge clk); while (in_stall);
    r = heap_apply(op, v);
    if (typed) r = typed_res;
    result_q.push_back(r);
  endtask

  function automatic int rand_key();
    case ($urandom_range(3))
      0: return $urandom_range(20) - 10;
      1: return $urandom_range(1) ? 32'h7fffffff - $urandom_range(3)
                                  : 32'h80000000 + $urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  // Pick an operation from insert / pop-min percentages; 4 percent is the unused opcode, the rest is pop-max
  function automatic op_t rand_op(int ins_pct, int min_pct);
    int r = $urandom_range(99);
    if (r < 4) return OP_NONE;
    if (r < 4 + ins_pct) return OP_INSERT;
    if (r < 4 + ins_pct + min_pct) return OP_POP_MIN;
    return OP_POP_MAX;
  endfunction

  // Receiver: random stall, or a long hold when asked
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 300;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    heap_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (result_q.size() == 0) begin
        $display("%0t: unexpected result removed=%0d count=%0d", $time,
                 out_removed_value, out_entry_count);
        error_cnt++;
      end else begin
        e = result_q.pop_front();
        result_cnt++;
        if (e.status == STAT_FULL) full_cnt++;
        if (e.status == STAT_EMPTY) empty_cnt++;
        if (out_removed_value !== e.removed) begin
          $display("%0t: removed_value exp %0d got %0d", $time, e.removed,
                   out_removed_value);
          error_cnt++;
        end
        if (out_entry_count !== e.count) begin
          $display("%0t: entry_count exp %0d got %0d", $time, e.count,
                   out_entry_count);
          error_cnt++;
        end
        if (out_running_total !== e.total) begin
          $display("%0t: running_total exp %0d got %0d", $time, e.total,
                   out_running_total);
          error_cnt++;
        end
        if (out_status !== e.status) begin
          $display("%0t: status exp %0d got %0d", $time, e.status, out_status);
          error_cnt++;
        end
      end
    end
  end

  // Directed requests: typed results where obvious, model elsewhere
  dir_row_t dir_tbl [23] = '{
    '{OP_POP_MIN, 0,           1'b1, '{0, 0, 0, STAT_EMPTY}},
    '{OP_POP_MAX, 0,           1'b1, '{0, 0, 0, STAT_EMPTY}},
    '{OP_NONE,    32'h1234,    1'b1, '{0, 0, 0, STAT_OK}},
    '{OP_INSERT,  32'h7fffffff, 1'b1, '{0, 1, 64'sd2147483647, STAT_OK}},
    '{OP_POP_MAX, 0,           1'b1, '{32'h7fffffff, 0, 0, STAT_OK}},
    '{OP_INSERT,  32'h80000000, 1'b1, '{0, 1, -64'sd2147483648, STAT_OK}},
    '{OP_POP_MIN, 0,           1'b1, '{32'h80000000, 0, 0, STAT_OK}},
    '{OP_INSERT,  5,           1'b0, '{0, 0, 0, STAT_OK}},
    '{OP_INSERT,  9,           1'b0, '{0, 0, 0, STAT_OK}},
    '{OP_POP_MAX, 0,           1'b0, '{0, 0, 0, STAT_OK}},
    '{OP_INSERT,  7,           1'b0, '{0, 0, 0, STAT_OK}},
    '{OP_INSERT,  7,           1'b0, '{0, 0, 0, STAT_OK}},
    '{OP_INSERT,  3,           1'b0, '{0, 0, 0, STAT_OK}},
    '{OP_POP_MAX, 0,           1'b0, '{0, 0, 0, STAT_OK}},
    '{OP_INSERT,  -1,          1'b0, '{0, 0, 0, STAT_OK}},
    '{OP_INSERT,  32'h55555555, 1'b0, '{0, 0, 0, STAT_OK}},
    '{OP_INSERT,  32'haaaaaaaa, 1'b0, '{0, 0, 0, STAT_OK}},
    '{OP_NONE,    -1,          1'b0, '{0, 0, 0, STAT_OK}},
    '{OP_POP_MIN, 0,           1'b0, '{0, 0, 0, STAT_OK}},
    '{OP_POP_MAX, 0,           1'b0, '{0, 0, 0, STAT_OK}},
    '{OP_POP_MIN, 0,           1'b0, '{0, 0, 0, STAT_OK}},
    '{OP_POP_MIN, 0,           1'b0, '{0, 0, 0, STAT_OK}},
    '{OP_POP_MIN, 0,           1'b0, '{0, 0, 0, STAT_OK}}
  };

  initial begin
    heap_result_t none_res;
    int extra;
    none_res = '{0, 0, 0, STAT_OK};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    send_idle_pct = 34;
    recv_idle_pct = 73;
    foreach (dir_tbl[k]) send_req(dir_tbl[k].op, dir_tbl[k].value, dir_tbl[k].typed,
                                  dir_tbl[k].res);

    // mixed traffic with a long receiver hold in the middle
    for (int k = 0; k < 150; k++) begin
      if (k == 50) hold_req <= ~hold_req;
      if (k == 100) begin
        in_valid <= 1'b0;
        while (result_q.size() != 0) @(posedge clk);
        @(posedge clk);
      end
      send_req(rand_op(50, 23), rand_key(), 1'b0, none_res);
    end

    // fill past capacity, swapped idling
    send_idle_pct = 73;
    recv_idle_pct = 34;
    extra = 0;
    while (extra < 8) begin
      if (heap_fill >= CAPACITY) extra++;
      send_req(($urandom_range(9) == 0) ? rand_op(0, 50) : OP_INSERT, rand_key(),
               1'b0, none_res);
    end

    // pop-heavy traffic, no idling
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int k = 0; k < 150; k++) send_req(rand_op(20, 38), rand_key(), 1'b0, none_res);
    in_valid <= 1'b0;

    while (result_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("tb_top: %0d results checked, %0d refused as full, %0d as empty",
             result_cnt, full_cnt, empty_cnt);
    if (error_cnt == 0 && result_q.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb_top: timeout");
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
